/* design/pttm_pkg.sv */
// Shared types and constants of the pose template tolerance matcher.
`timescale 1ns / 1ps

package pttm_pkg;

  // Fixed field widths of the stream beats
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned POSE_W  = 3;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 8;

  // Configuration register widths and indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned THRESH_W    = 16;
  localparam int unsigned TIU_W       = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMPLATES_IN_USE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_MASK      = 2'd2;

  // Input beat kinds carried on tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

/* design/pose_template_tolerance_match_top.sv */
// Top level of the pose template matcher with per-element tolerance.
`timescale 1ns / 1ps
//
//  channel | direction | handshake        | contents
//  --------+-----------+------------------+------------------------------------------
//  s_*     | in        | tvalid / tready  | tuser command, tdata slot/index/value, tlast
//  m_*     | out       | tvalid / tready  | tdata matched/pose_index, one beat per query
//  cfg_*   | in        | cfg_we only      | threshold, templates_in_use, active_mask
//
//  A load beat is written to the template RAM as it is accepted. A compared query beat
//  is checked against the templates in turn: the single RAM read port yields one
//  template element per cycle. Other query beats are not compared. A last query beat
//  then goes to ST_FINISH to pick the result, and waits there while m_tready is low
//  and the result register is still full. The RAM is not cleared by reset.

module pose_template_tolerance_match_top #(
  parameter int unsigned NUM_TEMPLATES  = 8,
  parameter int unsigned NUM_ELEMENTS   = 64,
  parameter int unsigned FIRST_COMPARED = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pttm_pkg::IN_DATA_W-1:0]     s_tdata,   // template_slot[2:0],
                                                        // element_index[8:3],
                                                        // value[24:9], zeros above
  input  logic                               s_tuser,   // command
  input  logic                               s_tlast,   // last
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pttm_pkg::OUT_DATA_W-1:0]    m_tdata,   // matched[0], pose_index[3:1],
                                                        // zeros above
  // Configuration writes
  input  logic                               cfg_we,
  input  logic [pttm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pttm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import pttm_pkg::*;

  localparam int unsigned TW     = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
  localparam int unsigned EW     = $clog2(NUM_ELEMENTS);
  localparam int unsigned AW     = TW + EW;
  localparam int unsigned DEPTH  = 1 << AW;
  localparam int unsigned WIDE_W = 7;

  // Input field views
  logic                       in_cmd;
  logic [SLOT_W-1:0]          in_slot;
  logic [INDEX_W-1:0]         in_idx;
  logic [VALUE_W-1:0]         in_value;
  logic                       in_last;
  logic                       in_accept;
  logic                       in_compared;
  logic                       in_load_ok;
  logic [WIDE_W-1:0]          slot_wide;

  // State
  state_t                     state;
  state_t                     state_next;
  logic [TW-1:0]              scan_t;
  logic [TW-1:0]              scan_t_plus;
  logic [EW-1:0]              idx_q;
  logic signed [VALUE_W-1:0]  val_q;
  logic                       last_q;
  logic [NUM_TEMPLATES-1:0]   still_matching;

  // Configuration
  logic [THRESH_W-1:0]        threshold;
  logic [TIU_W-1:0]           templates_in_use;
  logic [CFG_DATA_W-1:0]      active_mask;

  // RAM port
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [AW-1:0]              ram_raddr;
  logic [VALUE_W-1:0]         ram_rdata;

  // Compare and pick
  logic signed [VALUE_W:0]    diff;
  logic [VALUE_W:0]           abs_diff;
  logic                       elem_fail;
  logic                       pick_hit;
  logic [POSE_W-1:0]          pick_t;
  logic                       out_free;

  assign in_cmd    = s_tuser;
  assign in_slot   = s_tdata[SLOT_W-1:0];
  assign in_idx    = s_tdata[SLOT_W +: INDEX_W];
  assign in_value  = s_tdata[SLOT_W+INDEX_W +: VALUE_W];
  assign in_last   = s_tlast;
  assign in_accept = s_tvalid && s_tready;
  assign slot_wide = {{(WIDE_W-SLOT_W){1'b0}}, in_slot};

  // Decide whether a query beat is compared and whether a load lands in the RAM
  assign in_compared = ({1'b0, in_idx} >= WIDE_W'(FIRST_COMPARED)) &&
                       ({1'b0, in_idx} <  WIDE_W'(NUM_ELEMENTS)) &&
                       active_mask[in_idx];
  assign in_load_ok  = (slot_wide < WIDE_W'(NUM_TEMPLATES)) &&
                       ({1'b0, in_idx} < WIDE_W'(NUM_ELEMENTS));

  assign scan_t_plus = scan_t + TW'(1);
  assign ram_waddr   = {slot_wide[TW-1:0], in_idx[EW-1:0]};
  assign out_free    = !m_tvalid || m_tready;

  pttm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Difference of the held query element against the template element just read
  always_comb begin
    diff      = {val_q[VALUE_W-1], val_q} - {ram_rdata[VALUE_W-1], ram_rdata};
    abs_diff  = diff[VALUE_W] ? (VALUE_W+1)'(-diff) : diff;
    elem_fail = abs_diff > {1'b0, threshold};
  end

  // Pick the lowest matching template among those in use
  always_comb begin
    pick_hit = 1'b0;
    pick_t   = '0;
    for (int t = NUM_TEMPLATES - 1; t >= 0; t--) begin
      if (still_matching[t] && (WIDE_W'(t) < {3'b000, templates_in_use})) begin
        pick_hit = 1'b1;
        pick_t   = POSE_W'(t);
      end
    end
  end

  // Next state, RAM control and input ready
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = {{TW{1'b0}}, in_idx[EW-1:0]};
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (in_accept) begin
          if (in_cmd == CMD_LOAD) begin
            ram_we = in_load_ok;
          end else if (in_compared) begin
            state_next = ST_SCAN;
          end else if (in_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = {scan_t_plus, idx_q};
        if (scan_t == TW'(NUM_TEMPLATES - 1)) begin
          state_next = last_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the query beat and step through the templates
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      idx_q  <= in_idx[EW-1:0];
      val_q  <= in_value;
      last_q <= in_last;
    end
    if (rst) begin
      scan_t <= '0;
    end else if (state == ST_SCAN) begin
      scan_t <= (scan_t == TW'(NUM_TEMPLATES - 1)) ? '0 : scan_t_plus;
    end
  end

  // Drop templates that miss the tolerance; rearm after each result
  always_ff @(posedge clk) begin
    if (rst) begin
      still_matching <= '1;
    end else if (state == ST_SCAN) begin
      if (elem_fail) begin
        still_matching[scan_t] <= 1'b0;
      end
    end else if (state == ST_FINISH && out_free) begin
      still_matching <= '1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {{(OUT_DATA_W-POSE_W-1){1'b0}}, pick_t, pick_hit};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold        <= '0;
      templates_in_use <= '0;
      active_mask      <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:        threshold        <= cfg_data[THRESH_W-1:0];
        CFG_TEMPLATES_IN_USE: templates_in_use <= cfg_data[TIU_W-1:0];
        CFG_ACTIVE_MASK:      active_mask      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Checks
  a_no_match_zero_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[POSE_W:1] == '0))
    else $error("result without a match carries a nonzero pose index");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside the pick step");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (WIDE_W'(scan_t) < WIDE_W'(NUM_TEMPLATES)))
    else $error("template counter beyond the template count");

  a_last_unchecked_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_accept && in_cmd == CMD_QUERY && !in_compared && in_last)
      |=> (state == ST_FINISH))
    else $error("uncompared last query beat did not end the query");

endmodule

/* design/pttm_ram.sv */
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps

module pttm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* test/tb_pose_template_tolerance_match_top.sv */
// Self-checking testbench of the pose template matcher: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_pose_template_tolerance_match_top;
  import pttm_pkg::*;

  localparam int unsigned N_TMPL        = 8;
  localparam int unsigned N_ELEM        = 64;
  localparam int unsigned FIRST_CMP     = 6;
  localparam int unsigned RANDOM_BEATS  = 850;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned LONG_HOLD     = 600;
  localparam logic [63:0] MASK_ALL      = '1;
  localparam logic [63:0] MASK_TOP      = 64'h8000_0000_0000_003F;

  typedef struct packed {
    logic               cmd;
    logic [SLOT_W-1:0]  slot;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] value;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic              matched;
    logic [POSE_W-1:0] pose;
  } pose_res_t;

  typedef enum logic {ROW_BEAT, ROW_REGS} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    beat_t               b;
    logic [THRESH_W-1:0] thr;
    logic [TIU_W-1:0]    tiu;
    logic [63:0]         mask;
    bit                  has_exp;
    pose_res_t           exp_res;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;   // template_slot, element_index, value, zeros above
  logic                   s_tuser;   // command
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;   // matched, pose_index, zeros above
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pose_template_tolerance_match_top #(
    .NUM_TEMPLATES (N_TMPL),
    .NUM_ELEMENTS  (N_ELEM),
    .FIRST_COMPARED(FIRST_CMP)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Matcher state as the testbench sees it
  logic [VALUE_W-1:0]  tmpl_mem [N_TMPL][N_ELEM];
  bit                  tmpl_written [N_TMPL][N_ELEM];
  logic [VALUE_W-1:0]  col_base [N_ELEM];
  logic [N_TMPL-1:0]   alive;
  logic [THRESH_W-1:0] thr_reg;
  logic [TIU_W-1:0]    tiu_reg;
  logic [63:0]         mask_reg;

  pose_res_t   pending_poses[$];
  row_t        plan[$];
  bit          valid_held;
  int unsigned burst_left;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned errors;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one accepted beat to the matcher state; report the result it causes
  function automatic void pose_match_step(input beat_t b, output bit emits,
                                          output pose_res_t r);
    int t;
    int diff;
    int unsigned lim;
    bit found;
    emits = 1'b0;
    r = '0;
    if (b.cmd == CMD_LOAD) begin
      tmpl_mem[b.slot][b.idx] = b.value;
      tmpl_written[b.slot][b.idx] = 1'b1;
      return;
    end
    // leading and masked elements are never compared
    if (b.idx >= FIRST_CMP && mask_reg[b.idx]) begin
      for (t = 0; t < N_TMPL; t++) begin
        diff = int'($signed(b.value)) - int'($signed(tmpl_mem[t][b.idx]));
        if (diff < 0) diff = -diff;
        if (diff > int'(thr_reg)) alive[t] = 1'b0;
      end
    end
    if (!b.last) return;
    emits = 1'b1;
    lim = (tiu_reg > N_TMPL) ? N_TMPL : tiu_reg;
    found = 1'b0;
    for (t = 0; t < int'(lim); t++) begin
      if (!found && alive[t]) begin
        found = 1'b1;
        r.matched = 1'b1;
        r.pose = POSE_W'(t);
      end
    end
    alive = '1;
  endfunction

  function automatic bit column_loaded(input logic [INDEX_W-1:0] idx);
    int t;
    for (t = 0; t < N_TMPL; t++)
      if (!tmpl_written[t][idx]) return 1'b0;
    return 1'b1;
  endfunction

  // A query element may only touch template entries that hold data
  function automatic bit index_safe(input logic [INDEX_W-1:0] idx);
    if (idx < FIRST_CMP || !mask_reg[idx]) return 1'b1;
    return column_loaded(idx);
  endfunction

  function automatic void push_regs(input logic [THRESH_W-1:0] thr,
                                    input logic [TIU_W-1:0] tiu, input logic [63:0] mask);
    row_t row;
    row = '{kind: ROW_REGS, b: '0, thr: thr, tiu: tiu, mask: mask, has_exp: 1'b0,
            exp_res: '0};
    plan.push_back(row);
  endfunction

  function automatic void push_load(input logic [SLOT_W-1:0] slot,
                                    input logic [INDEX_W-1:0] idx,
                                    input logic [VALUE_W-1:0] value, input logic last);
    row_t row;
    row = '{kind: ROW_BEAT, b: '{CMD_LOAD, slot, idx, value, last}, thr: '0, tiu: '0,
            mask: '0, has_exp: 1'b0, exp_res: '0};
    plan.push_back(row);
  endfunction

  function automatic void push_query(input logic [INDEX_W-1:0] idx,
                                     input logic [VALUE_W-1:0] value, input logic last,
                                     input bit has_exp, input logic matched,
                                     input logic [POSE_W-1:0] pose);
    row_t row;
    row = '{kind: ROW_BEAT, b: '{CMD_QUERY, '0, idx, value, last}, thr: '0, tiu: '0,
            mask: '0, has_exp: has_exp, exp_res: '{matched, pose}};
    plan.push_back(row);
  endfunction

  // Offer one beat, hold it until taken, then predict and maybe pause the sender
  task automatic send_beat(input beat_t b, input bit has_exp, input pose_res_t typed);
    bit emits;
    pose_res_t pred;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= b.cmd;
    s_tlast  <= b.last;
    s_tdata  <= {{(IN_DATA_W-SLOT_W-INDEX_W-VALUE_W){1'b0}}, b.value, b.idx, b.slot};
    valid_held = 1'b1;
    do @(posedge clk); while (!s_tready);
    pose_match_step(b, emits, pred);
    if (emits) pending_poses.push_back(has_exp ? typed : pred);
    beats_sent++;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      valid_held = 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Wait for every expected result, then let the compare pipeline run dry
  task automatic drain_and_settle();
    if (valid_held) begin
      s_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    do @(posedge clk); while (pending_poses.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [THRESH_W-1:0] thr, input logic [TIU_W-1:0] tiu,
                            input logic [63:0] mask);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_data  <= CFG_DATA_W'(thr);
    @(posedge clk);
    thr_reg = thr;
    cfg_index <= CFG_TEMPLATES_IN_USE;
    cfg_data  <= CFG_DATA_W'(tiu);
    @(posedge clk);
    tiu_reg = tiu;
    cfg_index <= CFG_ACTIVE_MASK;
    cfg_data  <= mask;
    @(posedge clk);
    mask_reg = mask;
    cfg_we <= 1'b0;
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    pose_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_poses.size() == 0) begin
        $error("unexpected result beat: m_tdata=%h", m_tdata);
        errors++;
      end else begin
        want = pending_poses.pop_front();
        if (m_tdata[0] !== want.matched) begin
          $error("matched: expected %0d, actual %0d", want.matched, m_tdata[0]);
          errors++;
        end
        if (m_tdata[3:1] !== want.pose) begin
          $error("pose_index: expected %0d, actual %0d", want.pose, m_tdata[3:1]);
          errors++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result side: runs of readiness patterns, plus one long hold to back up the input
  initial begin : result_sink
    int unsigned run;
    int unsigned mode;
    bit held_long;
    held_long = 1'b0;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_long && results_seen >= 30) begin
        held_long = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(1, 40);
      repeat (run) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    beat_t b;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] base;
    logic [THRESH_W-1:0] thr;
    logic [TIU_W-1:0] tiu;
    logic [63:0] mask;
    logic [INDEX_W-1:0] ready_cols[$];
    int unsigned spread;
    int unsigned len;
    int unsigned phase_end;
    int unsigned stop_at;
    int unsigned pick;
    int t;
    int i;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_LOAD;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    valid_held = 1'b0;
    burst_left = 0;
    beats_sent = 0;
    results_seen = 0;
    errors = 0;
    idle_cycles = 0;
    for (t = 0; t < N_TMPL; t++)
      for (i = 0; i < N_ELEM; i++) begin
        tmpl_mem[t][i] = '0;
        tmpl_written[t][i] = 1'b0;
      end
    for (i = 0; i < N_ELEM; i++) col_base[i] = '0;
    alive = '1;
    thr_reg = '0;
    tiu_reg = '0;
    mask_reg = MASK_ALL;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: only element 63 gets template data here
    push_query(6'd0, 16'h0000, 1'b1, 1'b1, 1'b0, 3'd0);      // no templates after reset
    push_regs(16'd0, 4'd8, MASK_TOP);
    push_load(3'd0, 6'd63, 16'h7FFF, 1'b1);                   // last is ignored on a load
    push_load(3'd1, 6'd63, 16'h8000, 1'b0);
    push_load(3'd2, 6'd63, 16'd100, 1'b0);
    push_load(3'd3, 6'd63, 16'hFF9C, 1'b1);
    push_load(3'd4, 6'd63, 16'h0000, 1'b0);
    push_load(3'd5, 6'd63, 16'd5, 1'b0);
    push_load(3'd6, 6'd63, 16'hFFFF, 1'b0);
    push_load(3'd7, 6'd63, 16'd64, 1'b0);
    push_query(6'd63, 16'h7FFF, 1'b1, 1'b1, 1'b1, 3'd0);
    push_query(6'd63, 16'h8000, 1'b1, 1'b1, 1'b1, 3'd1);
    push_query(6'd63, 16'd5, 1'b1, 1'b1, 1'b1, 3'd5);
    push_query(6'd63, 16'd7, 1'b1, 1'b1, 1'b0, 3'd0);         // nothing within zero tolerance
    push_regs(16'hFFFF, 4'd8, MASK_TOP);
    push_query(6'd63, 16'h8000, 1'b1, 1'b1, 1'b1, 3'd0);      // widest difference still passes
    push_regs(16'd0, 4'd15, MASK_TOP);                        // count above the table size
    push_query(6'd63, 16'd64, 1'b1, 1'b1, 1'b1, 3'd7);
    push_query(6'd63, 16'd64, 1'b0, 1'b0, 1'b0, 3'd0);        // same element twice
    push_query(6'd63, 16'd5, 1'b1, 1'b1, 1'b0, 3'd0);
    push_regs(16'd0, 4'd8, 64'd0);                            // every element masked off
    push_query(6'd63, 16'd7, 1'b1, 1'b1, 1'b1, 3'd0);
    push_regs(16'd0, 4'd8, MASK_ALL);
    push_query(6'd3, 16'h8000, 1'b0, 1'b0, 1'b0, 3'd0);       // leading element, not compared
    push_query(6'd63, 16'd100, 1'b1, 1'b1, 1'b1, 3'd2);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REGS) begin
        drain_and_settle();
        write_regs(plan[i].thr, plan[i].tiu, plan[i].mask);
      end else begin
        send_beat(plan[i].b, plan[i].has_exp, plan[i].exp_res);
      end
    end

    // Random phases: new settings, then loads and queries built on loaded columns
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      drain_and_settle();
      case ($urandom_range(0, 3))
        0: thr = '0;
        1: thr = '1;
        2: thr = THRESH_W'($urandom_range(0, 200));
        default: thr = THRESH_W'($urandom);
      endcase
      tiu = ($urandom_range(0, 2) == 0) ? TIU_W'($urandom_range(0, 15)) : TIU_W'(N_TMPL);
      case ($urandom_range(0, 3))
        0: mask = MASK_ALL;
        1: mask = '0;
        2: mask = {$urandom, $urandom};
        default: mask = {$urandom, $urandom} | {$urandom, $urandom};
      endcase
      write_regs(thr, tiu, mask);

      phase_end = beats_sent + $urandom_range(30, 120);
      while (beats_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          // fill one element of every template around a common base
          idx = INDEX_W'($urandom_range(0, N_ELEM - 1));
          if ($urandom_range(0, 7) == 0) base = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          else base = VALUE_W'($urandom);
          spread = $urandom_range(0, 64);
          for (t = 0; t < N_TMPL; t++) begin
            b.cmd   = CMD_LOAD;
            b.slot  = SLOT_W'(t);
            b.idx   = idx;
            b.value = base + VALUE_W'($urandom_range(0, 2 * spread)) - VALUE_W'(spread);
            b.last  = 1'($urandom_range(0, 1));
            send_beat(b, 1'b0, '0);
          end
          col_base[idx] = base;
        end else if (pick < 75) begin
          // well-formed query near the loaded bases
          ready_cols.delete();
          for (i = 0; i < N_ELEM; i++)
            if (column_loaded(INDEX_W'(i))) ready_cols.push_back(INDEX_W'(i));
          len = $urandom_range(1, 6);
          spread = $urandom_range(0, 120);
          for (i = 0; i < int'(len); i++) begin
            if (ready_cols.size() == 0 || $urandom_range(0, 4) == 0)
              idx = INDEX_W'($urandom_range(0, FIRST_CMP - 1));
            else
              idx = ready_cols[$urandom_range(0, ready_cols.size() - 1)];
            b.cmd   = CMD_QUERY;
            b.slot  = SLOT_W'($urandom);
            b.idx   = idx;
            b.value = col_base[idx] + VALUE_W'($urandom_range(0, 2 * spread))
                      - VALUE_W'(spread);
            b.last  = (i == int'(len) - 1);
            send_beat(b, 1'b0, '0);
          end
        end else if (pick < 88) begin
          // stray load anywhere in the table
          b.cmd   = CMD_LOAD;
          b.slot  = SLOT_W'($urandom);
          b.idx   = INDEX_W'($urandom);
          b.value = VALUE_W'($urandom);
          b.last  = 1'($urandom_range(0, 1));
          send_beat(b, 1'b0, '0);
        end else begin
          // noise query element; fold unsafe indexes onto the leading ones
          idx = INDEX_W'($urandom);
          if (!index_safe(idx)) idx = INDEX_W'(idx % FIRST_CMP);
          b.cmd   = CMD_QUERY;
          b.slot  = SLOT_W'($urandom);
          b.idx   = idx;
          b.value = VALUE_W'($urandom);
          b.last  = 1'($urandom_range(0, 1));
          send_beat(b, 1'b0, '0);
        end
      end
    end

    drain_and_settle();
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
